/* src/euler_zyx_rotation_matrix_top_defines.svh */
// Assertion macros for the ZYX rotation matrix block.
// Each macro expects clk and rst_n in scope.
`ifndef EULER_ZYX_ROTATION_MATRIX_TOP_DEFINES_SVH
`define EULER_ZYX_ROTATION_MATRIX_TOP_DEFINES_SVH

// Same-cycle implication
`define EZYX_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ezyx: same-cycle check failed");

// Next-cycle implication
`define EZYX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ezyx: next-cycle check failed");

`endif

/* src/ezyx_pkg.sv */
package ezyx_pkg;

    // Trig table geometry (power of two, 256 to 4096 entries per turn)
    localparam int TRIG_TABLE_ENTRIES = 4096;
    localparam int ANGLE_BITS         = 12;
    localparam int IDX_W              = $clog2(TRIG_TABLE_ENTRIES);
    localparam int IDX_SHIFT          = ANGLE_BITS - IDX_W;
    localparam int QTR                = TRIG_TABLE_ENTRIES / 4;
    localparam int QW                 = IDX_W - 2;
    localparam int TAB_AW             = $clog2(QTR + 1);

    // Q12 formats
    localparam int Q_SHIFT = 12;
    localparam int TRIG_W  = Q_SHIFT + 1;   // unsigned 0..4096
    localparam int SC_W    = Q_SHIFT + 2;   // signed -4096..4096
    localparam int DATA_W  = 16;

    localparam logic [63:0] HALF_PI_Q62  = 64'h6487ED5110B4611A;
    localparam logic [63:0] ONE_Q62      = 64'h4000000000000000;
    localparam logic [63:0] ROUND_Q62    = 64'h0002000000000000;
    localparam int          SERIES_TERMS = 16;

    // Phase step per table entry, whole part and remainder
    localparam logic [63:0] PHI_STEP = HALF_PI_Q62 / 64'(TRIG_TABLE_ENTRIES);
    localparam logic [63:0] PHI_REM  = HALF_PI_Q62 % 64'(TRIG_TABLE_ENTRIES);

    // Series divisors as reciprocals: m = ceil(2^75 / d), exact floor for
    // 64-bit dividends and divisors up to 2^11
    localparam int                 RECIP_W   = 75;
    localparam logic [RECIP_W:0]   RECIP_NUM = {1'b1, {RECIP_W{1'b0}}};

    // sine terms divide by (2k)(2k+1)
    localparam logic [1:SERIES_TERMS][RECIP_W-1:0] SIN_RECIP = '{
        RECIP_W'((RECIP_NUM + 76'd5) / 76'd6),
        RECIP_W'((RECIP_NUM + 76'd19) / 76'd20),
        RECIP_W'((RECIP_NUM + 76'd41) / 76'd42),
        RECIP_W'((RECIP_NUM + 76'd71) / 76'd72),
        RECIP_W'((RECIP_NUM + 76'd109) / 76'd110),
        RECIP_W'((RECIP_NUM + 76'd155) / 76'd156),
        RECIP_W'((RECIP_NUM + 76'd209) / 76'd210),
        RECIP_W'((RECIP_NUM + 76'd271) / 76'd272),
        RECIP_W'((RECIP_NUM + 76'd341) / 76'd342),
        RECIP_W'((RECIP_NUM + 76'd419) / 76'd420),
        RECIP_W'((RECIP_NUM + 76'd505) / 76'd506),
        RECIP_W'((RECIP_NUM + 76'd599) / 76'd600),
        RECIP_W'((RECIP_NUM + 76'd701) / 76'd702),
        RECIP_W'((RECIP_NUM + 76'd811) / 76'd812),
        RECIP_W'((RECIP_NUM + 76'd929) / 76'd930),
        RECIP_W'((RECIP_NUM + 76'd1055) / 76'd1056)
    };

    // cosine terms divide by (2k-1)(2k)
    localparam logic [1:SERIES_TERMS][RECIP_W-1:0] COS_RECIP = '{
        RECIP_W'((RECIP_NUM + 76'd1) / 76'd2),
        RECIP_W'((RECIP_NUM + 76'd11) / 76'd12),
        RECIP_W'((RECIP_NUM + 76'd29) / 76'd30),
        RECIP_W'((RECIP_NUM + 76'd55) / 76'd56),
        RECIP_W'((RECIP_NUM + 76'd89) / 76'd90),
        RECIP_W'((RECIP_NUM + 76'd131) / 76'd132),
        RECIP_W'((RECIP_NUM + 76'd181) / 76'd182),
        RECIP_W'((RECIP_NUM + 76'd239) / 76'd240),
        RECIP_W'((RECIP_NUM + 76'd305) / 76'd306),
        RECIP_W'((RECIP_NUM + 76'd379) / 76'd380),
        RECIP_W'((RECIP_NUM + 76'd461) / 76'd462),
        RECIP_W'((RECIP_NUM + 76'd551) / 76'd552),
        RECIP_W'((RECIP_NUM + 76'd649) / 76'd650),
        RECIP_W'((RECIP_NUM + 76'd755) / 76'd756),
        RECIP_W'((RECIP_NUM + 76'd869) / 76'd870),
        RECIP_W'((RECIP_NUM + 76'd991) / 76'd992)
    };

    typedef struct packed {
        logic signed [DATA_W-1:0] angle_x;
        logic signed [DATA_W-1:0] angle_y;
        logic signed [DATA_W-1:0] angle_z;
    } angles_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] m00;
        logic signed [DATA_W-1:0] m01;
        logic signed [DATA_W-1:0] m02;
        logic signed [DATA_W-1:0] m10;
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m20;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m22;
    } matrix_t;

    // ROM read side control
    typedef struct packed {
        logic              en;
        logic [TAB_AW-1:0] addr_a;
        logic [TAB_AW-1:0] addr_b;
    } rom_req_t;

    // Quarter-wave table: entry j is sin(pi/2 * j/QTR) in Q12
    typedef logic [QTR:0][TRIG_W-1:0] trig_tab_t;

    // (a*b) >> 62 for Q62 operands
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // floor(x / d) from the reciprocal m of d
    function automatic logic [63:0] div_recip(input logic [63:0] x,
                                              input logic [RECIP_W-1:0] m);
        logic [RECIP_W+63:0] p;
        p = {{RECIP_W{1'b0}}, x} * {64'd0, m};
        return p[RECIP_W +: 64];
    endfunction

    // Series sine or cosine of (pi/2)*r/TRIG_TABLE_ENTRIES, rounded to Q12
    function automatic logic [TRIG_W-1:0] octant_val(input logic [63:0] r,
                                                     input logic want_cos);
        logic [63:0] phi;
        logic [63:0] phi2;
        logic [63:0] st;
        logic [63:0] ss;
        logic [63:0] ct;
        logic [63:0] cs;
        logic [63:0] sum;
        int          k;
        phi  = PHI_STEP * r + ((PHI_REM * r) >> IDX_W);
        phi2 = mul_q62(phi, phi);
        st   = phi;
        ss   = phi;
        ct   = ONE_Q62;
        cs   = ONE_Q62;
        for (k = 1; k <= SERIES_TERMS; k++)
        begin
            st = div_recip(mul_q62(st, phi2), SIN_RECIP[k]);
            ct = div_recip(mul_q62(ct, phi2), COS_RECIP[k]);
            if (k[0])
            begin
                ss = ss - st;
                cs = cs - ct;
            end
            else
            begin
                ss = ss + st;
                cs = cs + ct;
            end
        end
        sum = (want_cos ? cs : ss) + ROUND_Q62;
        return sum[50 +: TRIG_W];
    endfunction

    // Build the quarter-wave table at elaboration
    function automatic trig_tab_t build_trig_tab();
        trig_tab_t   tab;
        logic [63:0] r;
        int          j;
        for (j = 0; j <= QTR; j++)
        begin
            r = 64'(4 * j);
            if (2 * (4 * j) > TRIG_TABLE_ENTRIES)
            begin
                tab[j] = octant_val(64'(TRIG_TABLE_ENTRIES) - r, 1'b1);
            end
            else
            begin
                tab[j] = octant_val(r, 1'b0);
            end
        end
        return tab;
    endfunction

    localparam trig_tab_t TRIG_TAB = build_trig_tab();

endpackage

/* src/ezyx_angle_if.sv */
interface ezyx_angle_if;
    logic              valid;
    logic              ready;
    ezyx_pkg::angles_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/ezyx_matrix_if.sv */
interface ezyx_matrix_if;
    logic              valid;
    logic              ready;
    ezyx_pkg::matrix_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/euler_zyx_rotation_matrix_top.sv */
// ZYX Euler rotation matrix, Q12 in and out.
// An input transfer is registered in the ROM read, the signed sine and cosine, the
// first-level products and the output register before the output valid rises.
// Throughput: one item per cycle without backpressure; each stage holds one item.
// Stage 1 is the trig ROM read (one dual-read quarter-wave ROM per axis).
// Reset clears the stage valid bits only; datapath registers are not reset.
`include "euler_zyx_rotation_matrix_top_defines.svh"

module euler_zyx_rotation_matrix_top (
    input  logic                clk,
    input  logic                rst_n,
    ezyx_angle_if.sink          angles,
    ezyx_matrix_if.source       matrix
);

    localparam int AXES = 3;
    localparam int DW   = ezyx_pkg::DATA_W;
    localparam int SW   = ezyx_pkg::SC_W;
    localparam int TW   = ezyx_pkg::TRIG_W;
    localparam int AW   = ezyx_pkg::TAB_AW;

    // Quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] c;
    } sc_t;

    // Signed sine/cosine from quarter-wave values, quadrant and angle sign
    function automatic sc_t to_sc(input logic [TW-1:0] bs, input logic [TW-1:0] bc,
                                  input logic [1:0] quad, input logic neg);
        sc_t                  r;
        logic signed [SW-1:0] ps;
        logic signed [SW-1:0] pc;
        ps = signed'({1'b0, bs});
        pc = signed'({1'b0, bc});
        case (quad)
            QUAD_0:
            begin
                r.s = ps;
                r.c = pc;
            end
            QUAD_1:
            begin
                r.s = pc;
                r.c = -ps;
            end
            QUAD_2:
            begin
                r.s = -ps;
                r.c = -pc;
            end
            QUAD_3:
            begin
                r.s = -pc;
                r.c = ps;
            end
            default:
            begin
                r.s = ps;
                r.c = pc;
            end
        endcase
        if (neg)
        begin
            r.s = -r.s;
        end
        return r;
    endfunction

    // Q12 product; operands are small enough that the 30-bit product never wraps
    function automatic logic signed [DW-1:0] q12(input logic signed [DW-1:0] a,
                                                 input logic signed [SW-1:0] b);
        logic signed [DW+SW-1:0] p;
        p = a * b;
        return p[ezyx_pkg::Q_SHIFT +: DW];
    endfunction

    // Stage enables
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic en1;
    logic en2;
    logic en3;
    logic en4;

    assign en4 = !v4_reg || matrix.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign angles.ready = en1;

    // Stage 0: index and quadrant from the angle magnitude
    logic signed [DW-1:0]        ang      [AXES];
    logic [DW-1:0]               mag      [AXES];
    logic [ezyx_pkg::ANGLE_BITS-1:0] idx  [AXES];
    logic [ezyx_pkg::QW-1:0]     pos      [AXES];
    logic [1:0]                  quad     [AXES];
    ezyx_pkg::rom_req_t          rom_req  [AXES];
    logic [TW-1:0]               rom_s    [AXES];
    logic [TW-1:0]               rom_c    [AXES];

    assign ang[0] = angles.data.angle_x;
    assign ang[1] = angles.data.angle_y;
    assign ang[2] = angles.data.angle_z;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            mag[a]  = ang[a][DW-1] ? DW'(16'd0 - ang[a]) : ang[a];
            idx[a]  = mag[a][ezyx_pkg::ANGLE_BITS-1:0] >> ezyx_pkg::IDX_SHIFT;
            pos[a]  = idx[a][ezyx_pkg::QW-1:0];
            quad[a] = idx[a][ezyx_pkg::IDX_W-1 -: 2];
            rom_req[a].en     = en1;
            rom_req[a].addr_a = AW'(pos[a]);
            rom_req[a].addr_b = AW'(ezyx_pkg::QTR) - AW'(pos[a]);
        end
    end

    // Stage 1: ROM reads, quadrant and sign ride alongside
    logic [1:0] quad1_reg [AXES];
    logic       neg1_reg  [AXES];

    for (genvar g = 0; g < AXES; g++)
    begin : g_rom
        ezyx_trig_rom u_rom (
            .clk    (clk),
            .req    (rom_req[g]),
            .data_a (rom_s[g]),
            .data_b (rom_c[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                quad1_reg[a] <= quad[a];
                neg1_reg[a]  <= ang[a][DW-1];
            end
        end
    end

    // Stage 2: signed sine and cosine per axis
    sc_t sc2_reg [AXES];

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                sc2_reg[a] <= to_sc(rom_s[a], rom_c[a], quad1_reg[a], neg1_reg[a]);
            end
        end
    end

    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] cx;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] cy;
    logic signed [SW-1:0] sz;
    logic signed [SW-1:0] cz;

    assign sx = sc2_reg[0].s;
    assign cx = sc2_reg[0].c;
    assign sy = sc2_reg[1].s;
    assign cy = sc2_reg[1].c;
    assign sz = sc2_reg[2].s;
    assign cz = sc2_reg[2].c;

    // Stage 3: first-level products
    logic signed [DW-1:0] sxsy3_reg;
    logic signed [DW-1:0] sycx3_reg;
    logic signed [DW-1:0] cycz3_reg;
    logic signed [DW-1:0] szcx3_reg;
    logic signed [DW-1:0] sxsz3_reg;
    logic signed [DW-1:0] szcy3_reg;
    logic signed [DW-1:0] cxcz3_reg;
    logic signed [DW-1:0] sxcz3_reg;
    logic signed [DW-1:0] sxcy3_reg;
    logic signed [DW-1:0] cxcy3_reg;
    logic signed [DW-1:0] m20_3_reg;
    logic signed [SW-1:0] sz3_reg;
    logic signed [SW-1:0] cz3_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            sxsy3_reg <= q12(DW'(sx), sy);
            sycx3_reg <= q12(DW'(sy), cx);
            cycz3_reg <= q12(DW'(cy), cz);
            szcx3_reg <= q12(DW'(sz), cx);
            sxsz3_reg <= q12(DW'(sx), sz);
            szcy3_reg <= q12(DW'(sz), cy);
            cxcz3_reg <= q12(DW'(cx), cz);
            sxcz3_reg <= q12(DW'(sx), cz);
            sxcy3_reg <= q12(DW'(sx), cy);
            cxcy3_reg <= q12(DW'(cx), cy);
            m20_3_reg <= DW'(16'd0 - DW'(sy));
            sz3_reg   <= sz;
            cz3_reg   <= cz;
        end
    end

    // Stage 4: second-level products and sums into the output register
    ezyx_pkg::matrix_t out_next;
    ezyx_pkg::matrix_t out_reg;

    always_comb
    begin
        out_next.m00 = cycz3_reg;
        out_next.m01 = q12(sxsy3_reg, cz3_reg) - szcx3_reg;
        out_next.m02 = q12(sycx3_reg, cz3_reg) + sxsz3_reg;
        out_next.m10 = szcy3_reg;
        out_next.m11 = q12(sxsy3_reg, sz3_reg) + cxcz3_reg;
        out_next.m12 = q12(sycx3_reg, sz3_reg) - sxcz3_reg;
        out_next.m20 = m20_3_reg;
        out_next.m21 = sxcy3_reg;
        out_next.m22 = cxcy3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            out_reg <= out_next;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= angles.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    assign matrix.valid = v4_reg;
    assign matrix.data  = out_reg;

    // Checks
    `EZYX_ASSERT_NEXT(a_accept_enters, angles.valid && angles.ready, v1_reg)
    `EZYX_ASSERT_NEXT(a_stall_keeps_s3, v3_reg && v4_reg && !matrix.ready, v3_reg)
    `EZYX_ASSERT_NOW(a_sine_range, v2_reg, (sx <= 14'sd4096) && (sx >= -14'sd4096))
    `EZYX_ASSERT_NOW(a_cosine_range, v2_reg, (cz <= 14'sd4096) && (cz >= -14'sd4096))

endmodule

/* src/ezyx_trig_rom.sv */
// Quarter-wave sine ROM, two registered read ports
module ezyx_trig_rom (
    input  logic                                 clk,
    input  ezyx_pkg::rom_req_t                   req,
    output logic [ezyx_pkg::TRIG_W-1:0]          data_a,
    output logic [ezyx_pkg::TRIG_W-1:0]          data_b
);

    localparam ezyx_pkg::trig_tab_t ROM = ezyx_pkg::TRIG_TAB;

    logic [ezyx_pkg::TRIG_W-1:0] data_a_reg;
    logic [ezyx_pkg::TRIG_W-1:0] data_b_reg;

    // Read both ports when the stage advances
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            data_a_reg <= ROM[req.addr_a];
            data_b_reg <= ROM[req.addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

/* dv/ezyx_matrix_checker.sv */
module ezyx_matrix_checker (
    input  logic   clk,
    input  logic   rst_n,
    ezyx_angle_if  angles,
    ezyx_matrix_if matrix,
    output int     mismatches,
    output int     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  TURN    = ezyx_pkg::TRIG_TABLE_ENTRIES;
    localparam real HALF_PI = 1.5707963267948966;

    // Q12 sine and cosine per table step over one full turn
    logic signed [31:0] sin_steps [TURN];
    logic signed [31:0] cos_steps [TURN];

    // matrices predicted from accepted angle transfers, oldest first
    ezyx_pkg::matrix_t predicted_matrices [$];

    // fill the tables: round one quadrant, then fold by quadrant
    initial
    begin
        int  i;
        int  quad;
        int  r;
        int  bs;
        int  bc;
        real phase;
        for (i = 0; i < TURN; i++)
        begin
            quad  = (4 * i) / TURN;
            r     = 4 * i - quad * TURN;
            phase = HALF_PI * r / TURN;
            bs    = $rtoi($floor(4096.0 * $sin(phase) + 0.5));
            bc    = $rtoi($floor(4096.0 * $cos(phase) + 0.5));
            case (quad)
                0:
                begin
                    sin_steps[i] = bs;
                    cos_steps[i] = bc;
                end
                1:
                begin
                    sin_steps[i] = bc;
                    cos_steps[i] = -bs;
                end
                2:
                begin
                    sin_steps[i] = -bs;
                    cos_steps[i] = -bc;
                end
                default:
                begin
                    sin_steps[i] = -bc;
                    cos_steps[i] = bs;
                end
            endcase
        end
    end

    // table lookup on |angle| mod one turn; sine flips sign for negative angles
    function automatic void trig_of(input  logic signed [15:0] ang,
                                    output logic signed [31:0] s,
                                    output logic signed [31:0] c);
        logic [16:0] mag;
        int          idx;
        mag = ang[15] ? (17'h10000 - {1'b0, ang}) : {1'b0, ang};
        idx = (int'(mag[ezyx_pkg::ANGLE_BITS-1:0]) * TURN) >> ezyx_pkg::ANGLE_BITS;
        s   = sin_steps[idx];
        c   = cos_steps[idx];
        if (ang[15])
        begin
            s = -s;
        end
    endfunction

    // low 32 bits of the product, arithmetic shift by the Q12 point
    function automatic logic signed [31:0] q12_prod(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [63:0] full;
        logic signed [31:0] low;
        full = a * b;
        low  = full[31:0];
        return low >>> ezyx_pkg::Q_SHIFT;
    endfunction

    function automatic logic signed [15:0] low16(input logic signed [31:0] w);
        return w[15:0];
    endfunction

    // ZYX rotation matrix of one angle triple
    function automatic ezyx_pkg::matrix_t rotation_of(input ezyx_pkg::angles_t a);
        logic signed [31:0] sx;
        logic signed [31:0] cx;
        logic signed [31:0] sy;
        logic signed [31:0] cy;
        logic signed [31:0] sz;
        logic signed [31:0] cz;
        logic signed [31:0] sxsy;
        logic signed [31:0] sycx;
        ezyx_pkg::matrix_t  m;
        trig_of(a.angle_x, sx, cx);
        trig_of(a.angle_y, sy, cy);
        trig_of(a.angle_z, sz, cz);
        sxsy  = q12_prod(sx, sy);
        sycx  = q12_prod(sy, cx);
        m.m00 = low16(q12_prod(cy, cz));
        m.m01 = low16(q12_prod(sxsy, cz) - q12_prod(sz, cx));
        m.m02 = low16(q12_prod(sycx, cz) + q12_prod(sx, sz));
        m.m10 = low16(q12_prod(sz, cy));
        m.m11 = low16(q12_prod(sxsy, sz) + q12_prod(cx, cz));
        m.m12 = low16(q12_prod(sycx, sz) - q12_prod(sx, cz));
        m.m20 = low16(-sy);
        m.m21 = low16(q12_prod(sx, cy));
        m.m22 = low16(q12_prod(cx, cy));
        return m;
    endfunction

    function automatic int entry_wrong(input string field,
                                       input logic signed [15:0] want,
                                       input logic signed [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    // predict on every angle transfer, compare on every matrix transfer
    always @(posedge clk)
    begin
        int                bad;
        ezyx_pkg::matrix_t want;
        ezyx_pkg::matrix_t got;
        bad = 0;
        if (!rst_n)
        begin
            predicted_matrices.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (angles.valid && angles.ready)
            begin
                predicted_matrices.push_back(rotation_of(angles.data));
            end
            if (matrix.valid && matrix.ready)
            begin
                got = matrix.data;
                if (predicted_matrices.size() == 0)
                begin
                    $error("matrix transfer with no angle triple pending");
                    bad = 1;
                end
                else
                begin
                    want = predicted_matrices.pop_front();
                    bad  = entry_wrong("m00", want.m00, got.m00)
                         + entry_wrong("m01", want.m01, got.m01)
                         + entry_wrong("m02", want.m02, got.m02)
                         + entry_wrong("m10", want.m10, got.m10)
                         + entry_wrong("m11", want.m11, got.m11)
                         + entry_wrong("m12", want.m12, got.m12)
                         + entry_wrong("m20", want.m20, got.m20)
                         + entry_wrong("m21", want.m21, got.m21)
                         + entry_wrong("m22", want.m22, got.m22);
                end
            end
            mismatches  <= mismatches + bad;
            outstanding <= predicted_matrices.size();
        end
    end

endmodule

/* dv/tb_euler_zyx_rotation_matrix_top.sv */
module tb_euler_zyx_rotation_matrix_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1728;
    localparam int CALM_TAIL    = 200;
    localparam int SEGMENT      = 64;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic calm  = 1'b0;
    int   gap_pct   = 0;
    int   stall_pct = 0;
    int   cycle_count = 0;
    int   mismatches;
    int   outstanding;

    ezyx_angle_if  angles ();
    ezyx_matrix_if matrix ();

    always #1 clk = ~clk;

    euler_zyx_rotation_matrix_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .angles (angles),
        .matrix (matrix)
    );

    ezyx_matrix_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .angles      (angles),
        .matrix      (matrix),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_euler_zyx_rotation_matrix_top: errors");
            $finish;
        end
    end

    // downstream backpressure in random bursts
    initial
    begin
        matrix.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                matrix.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            matrix.ready <= 1'b1;
        end
    end

    // one angle transfer, with an optional idle burst ahead of it
    task automatic put_angles(input logic signed [15:0] ax,
                              input logic signed [15:0] ay,
                              input logic signed [15:0] az);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            angles.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        angles.valid <= 1'b1;
        angles.data  <= '{angle_x: ax, angle_y: ay, angle_z: az};
        @(posedge clk);
        while (!angles.ready)
        begin
            @(posedge clk);
        end
    endtask

    // mix of full range, one turn, quadrant edges and extremes
    function automatic logic signed [15:0] pick_angle();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 8191) - 4096;
            2:
            begin
                v = 1024 * $urandom_range(0, 31) + $urandom_range(0, 4) - 2;
                if ($urandom_range(0, 1))
                begin
                    v = -v;
                end
            end
            default:
            begin
                case ($urandom_range(0, 5))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = -32767;
                    3: v = 0;
                    4: v = -1;
                    default: v = 4096;
                endcase
            end
        endcase
        return v[15:0];
    endfunction

    initial
    begin
        int i;
        angles.valid <= 1'b0;
        angles.data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, unit steps, extremes, quadrants, wrap past one turn
        put_angles(0, 0, 0);
        put_angles(1, 0, 0);
        put_angles(0, 1, 0);
        put_angles(0, 0, 1);
        put_angles(-1, -1, -1);
        put_angles(32767, 32767, 32767);
        put_angles(-32768, -32768, -32768);
        put_angles(-32768, 1024, -1024);
        put_angles(1024, 1024, 1024);
        put_angles(2048, 2048, 2048);
        put_angles(3072, 3072, 3072);
        put_angles(-1024, -2048, -3072);
        put_angles(4095, 4096, 4097);
        put_angles(-4095, -4096, -4097);
        put_angles(5000, -5000, 12345);
        put_angles(512, 512, 512);
        put_angles(-512, 512, -512);
        put_angles(512, -512, 1536);
        put_angles(683, 341, -1365);
        put_angles(32767, -32768, 0);
        put_angles(-20480, 28672, -8193);

        // random part; idle rates change per segment, none at the tail
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % SEGMENT == 0)
            begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            if (i == RANDOM_ITEMS - CALM_TAIL)
            begin
                calm = 1'b1;
            end
            put_angles(pick_angle(), pick_angle(), pick_angle());
        end
        angles.valid <= 1'b0;

        // drain the pipeline, then watch for stray transfers
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("tb_euler_zyx_rotation_matrix_top: clean");
        end
        else
        begin
            $display("tb_euler_zyx_rotation_matrix_top: errors");
        end
        $finish;
    end

endmodule
